// File: design/circular_next_greater_store_assert.svh
// Assertion macros for the circular next greater store.
`ifndef CIRCULAR_NEXT_GREATER_STORE_ASSERT_SVH
`define CIRCULAR_NEXT_GREATER_STORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CNGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CNGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cngs_pkg.sv
// Shared types, codes and microprogram of the circular next greater store.
package cngs_pkg;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_LIST   = 2'd2;

    localparam logic [2:0] KIND_FOUND  = 3'd0;
    localparam logic [2:0] KIND_NONE   = 3'd1;
    localparam logic [2:0] KIND_LISTED = 3'd2;
    localparam logic [2:0] KIND_EMPTY  = 3'd3;
    localparam logic [2:0] KIND_FULL   = 3'd4;

    localparam int STEP_W = 5;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE     = 5'd0;
    localparam step_t S_DISP_Q   = 5'd1;
    localparam step_t S_DISP_L   = 5'd2;
    localparam step_t S_DISP_X   = 5'd3;
    localparam step_t S_APP_CHK  = 5'd4;
    localparam step_t S_APP_WR   = 5'd5;
    localparam step_t S_LST_CHK  = 5'd6;
    localparam step_t S_LST_CLR  = 5'd7;
    localparam step_t S_LST_RD   = 5'd8;
    localparam step_t S_LST_EMIT = 5'd9;
    localparam step_t S_LST_END  = 5'd10;
    localparam step_t S_EMPTY    = 5'd11;
    localparam step_t S_FULL     = 5'd12;
    localparam step_t S_Q_INIT   = 5'd13;
    localparam step_t S_Q_LOOP   = 5'd14;
    localparam step_t S_Q_RD     = 5'd15;
    localparam step_t S_Q_CUR    = 5'd16;
    localparam step_t S_Q_SCAN   = 5'd17;
    localparam step_t S_Q_STEP   = 5'd18;
    localparam step_t S_Q_CMP    = 5'd19;
    localparam step_t S_Q_MORE   = 5'd20;
    localparam step_t S_Q_NONE   = 5'd21;
    localparam step_t S_Q_FOUND  = 5'd22;
    localparam step_t S_Q_NEXT   = 5'd23;
    localparam step_t S_Q_DONE   = 5'd24;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_WRITE,
        OP_CLR_I,
        OP_RD_I_INC,
        OP_RD_I,
        OP_LOAD_CUR,
        OP_RD_POS,
        OP_INC_I,
        OP_EMIT_LIST,
        OP_EMIT_EMPTY,
        OP_EMIT_FULL,
        OP_PEND_NONE,
        OP_PEND_FOUND,
        OP_FLUSH
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_MODE_QUERY,
        C_MODE_LIST,
        C_NOT_APPEND,
        C_FULL,
        C_EMPTY,
        C_I_END,
        C_I_MORE,
        C_NEQ,
        C_J_END,
        C_J_MORE,
        C_SGT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic no_in;
        logic mode_query;
        logic mode_list;
        logic not_append;
        logic full;
        logic empty;
        logic i_end;
        logic neq;
        logic j_end;
        logic sgt;
    } cond_flags_t;

    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t w;
        case (step)
            S_IDLE:     w = '{OP_ACCEPT,     C_NO_IN,      S_IDLE};
            S_DISP_Q:   w = '{OP_NOP,        C_MODE_QUERY, S_Q_INIT};
            S_DISP_L:   w = '{OP_NOP,        C_MODE_LIST,  S_LST_CHK};
            S_DISP_X:   w = '{OP_NOP,        C_NOT_APPEND, S_IDLE};
            S_APP_CHK:  w = '{OP_NOP,        C_FULL,       S_FULL};
            S_APP_WR:   w = '{OP_WRITE,      C_ALWAYS,     S_IDLE};
            S_LST_CHK:  w = '{OP_NOP,        C_EMPTY,      S_EMPTY};
            S_LST_CLR:  w = '{OP_CLR_I,      C_NEVER,      S_IDLE};
            S_LST_RD:   w = '{OP_RD_I_INC,   C_NEVER,      S_IDLE};
            S_LST_EMIT: w = '{OP_EMIT_LIST,  C_I_MORE,     S_LST_RD};
            S_LST_END:  w = '{OP_NOP,        C_ALWAYS,     S_IDLE};
            S_EMPTY:    w = '{OP_EMIT_EMPTY, C_ALWAYS,     S_IDLE};
            S_FULL:     w = '{OP_EMIT_FULL,  C_ALWAYS,     S_IDLE};
            S_Q_INIT:   w = '{OP_CLR_I,      C_NEVER,      S_IDLE};
            S_Q_LOOP:   w = '{OP_NOP,        C_I_END,      S_Q_DONE};
            S_Q_RD:     w = '{OP_RD_I,       C_NEVER,      S_IDLE};
            S_Q_CUR:    w = '{OP_LOAD_CUR,   C_NEQ,        S_Q_NEXT};
            S_Q_SCAN:   w = '{OP_NOP,        C_J_END,      S_Q_NONE};
            S_Q_STEP:   w = '{OP_RD_POS,     C_NEVER,      S_IDLE};
            S_Q_CMP:    w = '{OP_NOP,        C_SGT,        S_Q_FOUND};
            S_Q_MORE:   w = '{OP_NOP,        C_J_MORE,     S_Q_STEP};
            S_Q_NONE:   w = '{OP_PEND_NONE,  C_ALWAYS,     S_Q_NEXT};
            S_Q_FOUND:  w = '{OP_PEND_FOUND, C_NEVER,      S_IDLE};
            S_Q_NEXT:   w = '{OP_INC_I,      C_ALWAYS,     S_Q_LOOP};
            S_Q_DONE:   w = '{OP_FLUSH,      C_ALWAYS,     S_IDLE};
            default:    w = '{OP_NOP,        C_ALWAYS,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: design/cngs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cngs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/cngs_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module cngs_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cngs_pkg::cond_flags_t flags,
    input  logic                 hold,
    output cngs_pkg::op_t        op
);

    cngs_pkg::step_t      step_reg;
    cngs_pkg::step_t      step_next;
    cngs_pkg::ctrl_word_t word;
    logic                 take;

    assign word = cngs_pkg::ucode(step_reg);
    assign op   = word.op;

    always_comb
    begin
        case (word.cond)
            cngs_pkg::C_NEVER:      take = 1'b0;
            cngs_pkg::C_ALWAYS:     take = 1'b1;
            cngs_pkg::C_NO_IN:      take = flags.no_in;
            cngs_pkg::C_MODE_QUERY: take = flags.mode_query;
            cngs_pkg::C_MODE_LIST:  take = flags.mode_list;
            cngs_pkg::C_NOT_APPEND: take = flags.not_append;
            cngs_pkg::C_FULL:       take = flags.full;
            cngs_pkg::C_EMPTY:      take = flags.empty;
            cngs_pkg::C_I_END:      take = flags.i_end;
            cngs_pkg::C_I_MORE:     take = !flags.i_end;
            cngs_pkg::C_NEQ:        take = flags.neq;
            cngs_pkg::C_J_END:      take = flags.j_end;
            cngs_pkg::C_J_MORE:     take = !flags.j_end;
            cngs_pkg::C_SGT:        take = flags.sgt;
            default:                take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (take)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = cngs_pkg::step_t'(step_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= cngs_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: design/circular_next_greater_store.sv
// Top level: circular next greater store, microcoded control over a RAM datapath.
//
//  channel  | handshake          | fields
//  ---------+--------------------+------------------------------
//  in       | in_valid/in_stall  | mode[1:0], value[31:0]
//  out      | out_valid/out_stall| result_value[31:0], kind[2:0], last
//
// Append checks for room, then writes the value or emits a full result.
// List reads and emits each stored value in order, or emits one empty result.
// Query scans, for each stored position holding the queried value, the other
// stored values circularly for the first greater one via the single read port.
// Reset clears the count and control state at once; no clearing pass is run.
// A stalled output holds the sequencer on its next emit step only.
`include "circular_next_greater_store_assert.svh"

module circular_next_greater_store #(
    parameter int CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_value,
    output logic [2:0]         kind,
    output logic               last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    cngs_pkg::op_t         op;
    cngs_pkg::cond_flags_t flags;
    logic                  hold;
    logic                  fire;
    logic                  out_free;
    logic                  needs_out;

    logic [1:0]         mode_reg,  mode_next;
    logic signed [31:0] key_reg,   key_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      i_reg,     i_next;
    logic [CW-1:0]      j_reg,     j_next;
    logic [AW-1:0]      pos_reg,   pos_next;
    logic signed [31:0] cur_reg,   cur_next;

    logic               pend_valid_reg, pend_valid_next;
    logic signed [31:0] pend_value_reg, pend_value_next;
    logic [2:0]         pend_kind_reg,  pend_kind_next;

    logic               out_valid_reg,    out_valid_next;
    logic signed [31:0] result_value_reg, result_value_next;
    logic [2:0]         kind_reg,         kind_next;
    logic               last_reg,         last_next;
    logic               out_load;

    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic signed [31:0] rdata;
    logic [CW-1:0]      pos_wide;
    logic [AW-1:0]      pos_step;

    cngs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .hold  (hold),
        .op    (op)
    );

    cngs_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign needs_out = (op == cngs_pkg::OP_EMIT_LIST) || (op == cngs_pkg::OP_EMIT_EMPTY)
                    || (op == cngs_pkg::OP_EMIT_FULL)
                    || (pend_valid_reg && ((op == cngs_pkg::OP_PEND_NONE)
                                        || (op == cngs_pkg::OP_PEND_FOUND)
                                        || (op == cngs_pkg::OP_FLUSH)));
    assign hold      = needs_out && !out_free;
    assign fire      = !hold;
    assign in_stall  = (op != cngs_pkg::OP_ACCEPT);

    assign flags.no_in      = !in_valid;
    assign flags.mode_query = (mode_reg == cngs_pkg::MODE_QUERY);
    assign flags.mode_list  = (mode_reg == cngs_pkg::MODE_LIST);
    assign flags.not_append = (mode_reg != cngs_pkg::MODE_APPEND);
    assign flags.full       = (count_reg == CW'(CAPACITY));
    assign flags.empty      = (count_reg == '0);
    assign flags.i_end      = (i_reg == count_reg);
    assign flags.neq        = (rdata != key_reg);
    assign flags.j_end      = (j_reg == count_reg);
    assign flags.sgt        = (rdata > cur_reg);

    assign pos_wide  = CW'(pos_reg) + CW'(1);
    assign pos_step  = (pos_wide == count_reg) ? '0 : pos_wide[AW-1:0];

    assign ram_we    = (op == cngs_pkg::OP_WRITE);
    assign ram_re    = (op == cngs_pkg::OP_RD_I) || (op == cngs_pkg::OP_RD_I_INC)
                    || (op == cngs_pkg::OP_RD_POS);
    assign ram_raddr = (op == cngs_pkg::OP_RD_POS) ? pos_step : i_reg[AW-1:0];

    always_comb
    begin
        mode_next         = mode_reg;
        key_next          = key_reg;
        count_next        = count_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        pos_next          = pos_reg;
        cur_next          = cur_reg;
        pend_valid_next   = pend_valid_reg;
        pend_value_next   = pend_value_reg;
        pend_kind_next    = pend_kind_reg;
        out_load          = 1'b0;
        result_value_next = result_value_reg;
        kind_next         = kind_reg;
        last_next         = last_reg;

        case (op)
            cngs_pkg::OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    key_next  = value;
                end
            end
            cngs_pkg::OP_WRITE:
            begin
                count_next = CW'(count_reg + 1'b1);
            end
            cngs_pkg::OP_CLR_I:
            begin
                i_next          = '0;
                pend_valid_next = 1'b0;
            end
            cngs_pkg::OP_RD_I_INC:
            begin
                i_next = CW'(i_reg + 1'b1);
            end
            cngs_pkg::OP_RD_I:
            begin
                pos_next = i_reg[AW-1:0];
                j_next   = CW'(1);
            end
            cngs_pkg::OP_LOAD_CUR:
            begin
                cur_next = rdata;
            end
            cngs_pkg::OP_RD_POS:
            begin
                pos_next = pos_step;
                j_next   = CW'(j_reg + 1'b1);
            end
            cngs_pkg::OP_INC_I:
            begin
                i_next = CW'(i_reg + 1'b1);
            end
            cngs_pkg::OP_EMIT_LIST:
            begin
                if (fire)
                begin
                    out_load          = 1'b1;
                    result_value_next = rdata;
                    kind_next         = cngs_pkg::KIND_LISTED;
                    last_next         = (i_reg == count_reg);
                end
            end
            cngs_pkg::OP_EMIT_EMPTY:
            begin
                if (fire)
                begin
                    out_load          = 1'b1;
                    result_value_next = '0;
                    kind_next         = cngs_pkg::KIND_EMPTY;
                    last_next         = 1'b1;
                end
            end
            cngs_pkg::OP_EMIT_FULL:
            begin
                if (fire)
                begin
                    out_load          = 1'b1;
                    result_value_next = '0;
                    kind_next         = cngs_pkg::KIND_FULL;
                    last_next         = 1'b1;
                end
            end
            cngs_pkg::OP_PEND_NONE, cngs_pkg::OP_PEND_FOUND:
            begin
                if (fire)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load          = 1'b1;
                        result_value_next = pend_value_reg;
                        kind_next         = pend_kind_reg;
                        last_next         = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    if (op == cngs_pkg::OP_PEND_FOUND)
                    begin
                        pend_value_next = rdata;
                        pend_kind_next  = cngs_pkg::KIND_FOUND;
                    end
                    else
                    begin
                        pend_value_next = '0;
                        pend_kind_next  = cngs_pkg::KIND_NONE;
                    end
                end
            end
            cngs_pkg::OP_FLUSH:
            begin
                if (fire && pend_valid_reg)
                begin
                    out_load          = 1'b1;
                    result_value_next = pend_value_reg;
                    kind_next         = pend_kind_reg;
                    last_next         = 1'b1;
                    pend_valid_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        key_reg          <= key_next;
        i_reg            <= i_next;
        j_reg            <= j_next;
        pos_reg          <= pos_next;
        cur_reg          <= cur_next;
        pend_value_reg   <= pend_value_next;
        pend_kind_reg    <= pend_kind_next;
        result_value_reg <= result_value_next;
        kind_reg         <= kind_next;
        last_reg         <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign kind         = kind_reg;
    assign last         = last_reg;

    `CNGS_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY), "count over capacity")
    `CNGS_ASSERT_IMP(a_write_room, clk, rst_n, ram_we, count_reg < CW'(CAPACITY), "write when full")
    `CNGS_ASSERT_IMP(a_pend_query, clk, rst_n, pend_valid_reg, mode_reg == cngs_pkg::MODE_QUERY, "pending outside query")
    `CNGS_ASSERT_NXT(a_accept_leaves, clk, rst_n, in_valid && !in_stall, in_stall, "accept did not advance")

endmodule
